>>> src/reverse_echo_stereo_delay_macros.svh
// Assertion macros shared by the reverse echo stereo delay RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef REVERSE_ECHO_STEREO_DELAY_MACROS_SVH
`define REVERSE_ECHO_STEREO_DELAY_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RESD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a result in the next cycle.
`define RESD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/resd_pkg.sv
// Shared types and constants for the reverse echo stereo delay.
// No dependencies; used by resd_mix_div and the top level.
package resd_pkg;

  // Sample and register widths.
  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 17;
  localparam int GAIN_W   = 16;
  localparam int DEN_W    = 17;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // Default number of stereo frames in the echo store.
  localparam int FRAMES_DEF = 131072;

  // Gain constants in Q1.16: 0.99 rounded, and 1.0.
  localparam logic [DEN_W-1:0] ZERO99_Q16 = 17'd64881;
  localparam logic [DEN_W-1:0] ONE_Q16    = 17'd65536;

  // Register indexes (byte address bits 3:2).
  localparam logic [1:0] REG_ECHO_LENGTH    = 2'd0;
  localparam logic [1:0] REG_FEEDBACK_DEPTH = 2'd1;
  localparam logic [1:0] REG_WET_LEVEL      = 2'd2;

  // Request into the shared mix divider.
  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic [GAIN_W-1:0]          gain;
    logic [DEN_W-1:0]           den;
  } div_req_t;

  // Response from the shared mix divider.
  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> src/reverse_echo_stereo_delay.sv
// Reverse echo stereo delay with feedback: top level, sequencer and register port.
// Depends on resd_pkg, resd_ram, resd_mix_div and the assertion macro header.
//
// One stereo item enters on the in_ stream; one mixed item leaves on the out_ stream.
// All arithmetic runs through one shared divider, so an item takes four divisions when
// wet_level is nonzero and two divisions when wet_level is zero (dry passthrough). After
// reset the block clears the echo store, one frame a cycle, and holds in_tready low
// meanwhile. A finished item waits in the output register while the next item is
// accepted. Writing feedback_depth rewinds the write position to zero.
`include "reverse_echo_stereo_delay_macros.svh"

module reverse_echo_stereo_delay #(
  parameter int MAX_FRAMES = resd_pkg::FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input stream; tdata: left_in [23:0], right_in [47:24].
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [47:0]               in_tdata,
  // Output stream; tdata: left_out [23:0], right_out [47:24].
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [47:0]               out_tdata,
  // Register port.
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [resd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [resd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [resd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  localparam int AW = $clog2(MAX_FRAMES);
  localparam int LW = (AW > resd_pkg::LEN_W) ? AW : resd_pkg::LEN_W;
  localparam int SW = resd_pkg::SAMPLE_W;
  localparam logic [LW-1:0] LAST_MAX = LW'(MAX_FRAMES - 1);
  localparam logic [AW-1:0] CLR_END  = AW'(MAX_FRAMES - 1);

  // Sequencer state codes.
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDO  = 4'd2;
  localparam logic [3:0] S_DL   = 4'd3;
  localparam logic [3:0] S_DR   = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_RQ   = 4'd6;
  localparam logic [3:0] S_RW   = 4'd7;
  localparam logic [3:0] S_WL   = 4'd8;
  localparam logic [3:0] S_WRR  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]                state_r, state_nxt;
  logic [AW-1:0]             clr_cnt_r;
  logic [AW-1:0]             pos_r, last_r;
  logic [resd_pkg::LEN_W-1:0] echo_length_r;
  logic [resd_pkg::GAIN_W-1:0] feedback_depth_r, wet_level_r;
  logic signed [SW-1:0]      xl_r, xr_r, nl_r, nr_r, yl_r, yr_r;
  logic [2*SW-1:0]           slot_r;
  logic [2*SW-1:0]           out_data_r;
  logic                      out_tvalid_r;
  logic                      start_r;

  logic                      in_acc, cfg_wr, out_load, div_state;
  logic [LW-1:0]             len_ext, last_w;
  logic [AW-1:0]             last_eff, pos_eff, rd_idx;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [2*SW-1:0]           ram_wdata, ram_rdata;
  resd_pkg::div_req_t        div_req;
  resd_pkg::div_rsp_t        div_rsp;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign out_load  = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
  assign div_state = (state_r == S_DL) || (state_r == S_DR) ||
                     (state_r == S_WL) || (state_r == S_WRR);

  // Window end clamped to the store, and the position pulled back into the window.
  assign len_ext  = LW'(echo_length_r);
  assign last_w   = (len_ext > LAST_MAX) ? LAST_MAX : len_ext;
  assign last_eff = last_w[AW-1:0];
  assign pos_eff  = (pos_r > last_eff) ? '0 : pos_r;
  assign rd_idx   = last_r - pos_r;

  // Echo store ports.
  assign ram_we    = (state_r == S_CLR) || (state_r == S_WR);
  assign ram_waddr = (state_r == S_CLR) ? clr_cnt_r : pos_r;
  assign ram_wdata = (state_r == S_CLR) ? '0 : {nr_r, nl_r};
  assign ram_raddr = (state_r == S_IDLE) ? pos_eff : rd_idx;

  resd_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Divider operands by sequencer state.
  always_comb begin
    div_req.start = start_r;
    div_req.a     = xl_r;
    div_req.b     = slot_r[SW-1:0];
    div_req.gain  = feedback_depth_r;
    div_req.den   = resd_pkg::ZERO99_Q16 + 17'(feedback_depth_r);
    case (state_r)
      S_DR: begin
        div_req.a = xr_r;
        div_req.b = slot_r[2*SW-1:SW];
      end
      S_WL: begin
        div_req.gain = wet_level_r;
        div_req.den  = resd_pkg::ONE_Q16 + 17'(wet_level_r);
      end
      S_WRR: begin
        div_req.a    = xr_r;
        div_req.b    = slot_r[2*SW-1:SW];
        div_req.gain = wet_level_r;
        div_req.den  = resd_pkg::ONE_Q16 + 17'(wet_level_r);
      end
      default: ;
    endcase
  end

  resd_mix_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_cnt_r == CLR_END) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_RDO;
      S_RDO:   state_nxt = S_DL;
      S_DL:    if (div_rsp.done) state_nxt = S_DR;
      S_DR:    if (div_rsp.done) state_nxt = S_WR;
      S_WR:    state_nxt = (wet_level_r == '0) ? S_FIN : S_RQ;
      S_RQ:    state_nxt = S_RW;
      S_RW:    state_nxt = S_WL;
      S_WL:    if (div_rsp.done) state_nxt = S_WRR;
      S_WRR:   if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLR;
      clr_cnt_r        <= '0;
      pos_r            <= '0;
      start_r          <= 1'b0;
      out_tvalid_r     <= 1'b0;
      echo_length_r    <= '0;
      feedback_depth_r <= '0;
      wet_level_r      <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == S_RDO) || (state_r == S_RW) ||
                 (div_rsp.done && ((state_r == S_DL) || (state_r == S_WL)));
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // Position: pulled into the window on accept, stepped on completion.
      if (in_acc) begin
        pos_r <= pos_eff;
      end else if (out_load) begin
        pos_r <= (pos_r == last_r) ? '0 : pos_r + 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      // Register writes.
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          resd_pkg::REG_ECHO_LENGTH:
            echo_length_r <= cfg_pwdata[resd_pkg::LEN_W-1:0];
          resd_pkg::REG_FEEDBACK_DEPTH: begin
            feedback_depth_r <= cfg_pwdata[resd_pkg::GAIN_W-1:0];
            pos_r            <= '0;
          end
          resd_pkg::REG_WET_LEVEL:
            wet_level_r <= cfg_pwdata[resd_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Sample and result registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xl_r   <= in_tdata[SW-1:0];
      xr_r   <= in_tdata[2*SW-1:SW];
      last_r <= last_eff;
    end
    if ((state_r == S_RDO) || (state_r == S_RW)) begin
      slot_r <= ram_rdata;
    end
    if (div_rsp.done) begin
      case (state_r)
        S_DL:    nl_r <= div_rsp.quot;
        S_DR:    nr_r <= div_rsp.quot;
        S_WL:    yl_r <= div_rsp.quot;
        S_WRR:   yr_r <= div_rsp.quot;
        default: ;
      endcase
    end
    // Dry passthrough when the wet level is zero.
    if ((state_r == S_WR) && (wet_level_r == '0)) begin
      yl_r <= xl_r;
      yr_r <= xr_r;
    end
    if (out_load) begin
      out_data_r <= {yr_r, yl_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Register read-back.
  always_comb begin
    unique case (cfg_paddr[3:2])
      resd_pkg::REG_ECHO_LENGTH:    cfg_prdata = 32'(echo_length_r);
      resd_pkg::REG_FEEDBACK_DEPTH: cfg_prdata = 32'(feedback_depth_r);
      resd_pkg::REG_WET_LEVEL:      cfg_prdata = 32'(wet_level_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // Checks on the sequencer.
  `RESD_ASSERT(a_no_accept_in_clear, (state_r == S_CLR) |-> !in_tready, "item accepted during clear")
  `RESD_ASSERT_NEXT(a_accept_reads, in_acc, state_r == S_RDO, "accept did not start a read")
  `RESD_ASSERT(a_done_in_div, div_rsp.done |-> div_state, "divider finished outside a divide state")
  `RESD_ASSERT(a_pos_in_window, (state_r == S_WR) |-> (pos_r <= last_r), "write slot beyond window")
  `RESD_ASSERT_NEXT(a_fin_loads, out_load, out_tvalid_r, "finished item not presented")

endmodule

>>> src/resd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module resd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/resd_mix_div.sv
// Shared mix unit: round((a*65536 + b*gain) / den), halves away from zero, saturated.
// Depends on resd_pkg for the request and response structs.
module resd_mix_div (
  input  logic              clk,
  input  logic              rst_n,
  input  resd_pkg::div_req_t req,
  output resd_pkg::div_rsp_t rsp
);

  localparam int SW    = resd_pkg::SAMPLE_W;
  localparam int STEPS = 13;
  localparam int QW    = 2 * STEPS;

  // Phase codes.
  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL  = 3'd1;
  localparam logic [2:0] P_SUM  = 3'd2;
  localparam logic [2:0] P_MAG  = 3'd3;
  localparam logic [2:0] P_NUM  = 3'd4;
  localparam logic [2:0] P_DIV  = 3'd5;
  localparam logic [2:0] P_SAT  = 3'd6;

  localparam logic [QW-1:0] POS_LIM = QW'(8388607);
  localparam logic [QW-1:0] NEG_LIM = QW'(8388608);

  logic [2:0]              ph_r, ph_nxt;
  logic signed [SW-1:0]    a_r, b_r;
  logic [15:0]             gain_r;
  logic [16:0]             den_r;
  logic signed [40:0]      prod_r;
  logic signed [41:0]      n_r;
  logic [40:0]             mag_r;
  logic                    neg_r;
  logic [17:0]             rem_r;
  logic [QW-1:0]           lo_r;
  logic [QW-1:0]           quo_r;
  logic [3:0]              cnt_r;
  logic [SW-1:0]           quot_r;
  logic                    done_r;

  logic [41:0]             num;
  logic [17:0]             d2;
  logic [18:0]             t1, t2;
  logic                    ge1, ge2;
  logic [17:0]             r1, r2;
  logic [SW-1:0]           sat_val;

  assign d2 = {den_r, 1'b0};
  assign num = 42'({mag_r, 1'b0}) + 42'(den_r);

  // Two restoring division steps per cycle.
  always_comb begin
    t1  = {rem_r, lo_r[QW-1]};
    ge1 = (t1 >= {1'b0, d2});
    r1  = ge1 ? 18'(t1 - {1'b0, d2}) : t1[17:0];
    t2  = {r1, lo_r[QW-2]};
    ge2 = (t2 >= {1'b0, d2});
    r2  = ge2 ? 18'(t2 - {1'b0, d2}) : t2[17:0];
  end

  // Apply the sign and saturate to 24 bits.
  always_comb begin
    if (!neg_r) begin
      sat_val = (quo_r > POS_LIM) ? 24'h7FFFFF : quo_r[SW-1:0];
    end else begin
      sat_val = (quo_r > NEG_LIM) ? 24'h800000 : SW'(-quo_r[SW-1:0]);
    end
  end

  // Phase sequencing.
  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      P_IDLE:  if (req.start) ph_nxt = P_MUL;
      P_MUL:   ph_nxt = P_SUM;
      P_SUM:   ph_nxt = P_MAG;
      P_MAG:   ph_nxt = P_NUM;
      P_NUM:   ph_nxt = P_DIV;
      P_DIV:   if (cnt_r == 4'(STEPS - 1)) ph_nxt = P_SAT;
      P_SAT:   ph_nxt = P_IDLE;
      default: ph_nxt = P_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= P_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == P_SAT);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (ph_r)
      P_IDLE: begin
        a_r    <= req.a;
        b_r    <= req.b;
        gain_r <= req.gain;
        den_r  <= req.den;
      end
      P_MUL: prod_r <= b_r * $signed({1'b0, gain_r});
      P_SUM: n_r <= $signed({{2{a_r[SW-1]}}, a_r, 16'b0}) + $signed({prod_r[40], prod_r});
      P_MAG: begin
        neg_r <= n_r[41];
        mag_r <= n_r[41] ? 41'(-n_r) : n_r[40:0];
      end
      P_NUM: begin
        rem_r <= {2'b0, num[41:QW]};
        lo_r  <= num[QW-1:0];
        quo_r <= '0;
        cnt_r <= '0;
      end
      P_DIV: begin
        rem_r <= r2;
        lo_r  <= {lo_r[QW-3:0], 2'b0};
        quo_r <= {quo_r[QW-3:0], ge1, ge2};
        cnt_r <= cnt_r + 4'd1;
      end
      P_SAT: quot_r <= sat_val;
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the reverse echo stereo delay (top module tb).
// Depends on resd_pkg and the reverse_echo_stereo_delay RTL; it needs no other file.

module tb;

  // The store is built small so that window wrap and length clamping can be reached.
  localparam int FRAMES      = 1024;
  localparam int SW          = resd_pkg::SAMPLE_W;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 104;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 200;

  // Register index that maps to no register.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic signed [SW-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] SAMPLE_MIN = 24'sh800000;

  // One stereo item: left in the low bits, right in the high bits.
  typedef struct packed {
    logic signed [SW-1:0] right;
    logic signed [SW-1:0] left;
  } stereo_t;

  // Tracks the echo store and the registers, and predicts every mixed item.
  class echo_mix_tracker;
    stereo_t     echo_slot [FRAMES];
    int unsigned write_pos;
    int unsigned echo_length;
    int unsigned feedback_depth;
    int unsigned wet_level;
    stereo_t     expected_mix [$];
    int          accepted;
    int          checked;
    int          mismatches;

    function new();
      foreach (echo_slot[i]) echo_slot[i] = '0;
      write_pos      = 0;
      echo_length    = 0;
      feedback_depth = 0;
      wet_level      = 0;
      accepted       = 0;
      checked        = 0;
      mismatches     = 0;
    endfunction

    // Register write; bits above each register's width are dropped.
    function void write_reg(logic [1:0] idx, logic [resd_pkg::CFG_DW-1:0] value);
      case (idx)
        resd_pkg::REG_ECHO_LENGTH: echo_length = value[resd_pkg::LEN_W-1:0];
        resd_pkg::REG_FEEDBACK_DEPTH: begin
          feedback_depth = value[resd_pkg::GAIN_W-1:0];
          write_pos      = 0;
        end
        resd_pkg::REG_WET_LEVEL: wet_level = value[resd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Computes (a*1.0 + b*gain) / den in Q0.16, rounded half away from zero, saturated.
    function logic signed [SW-1:0] mix_round(longint a, longint b, int unsigned gain,
                                             int unsigned den);
      longint          num;
      longint          quot;
      longint unsigned mag;
      num  = a * longint'(resd_pkg::ONE_Q16) + b * longint'(gain);
      mag  = (num < 0) ? -num : num;
      quot = longint'((mag * 64'd2 + 64'(den)) / (64'(den) * 64'd2));
      if (num < 0) quot = -quot;
      if (quot > 8388607) return SAMPLE_MAX;
      if (quot < -8388608) return SAMPLE_MIN;
      return quot[SW-1:0];
    endfunction

    // Updates the store for one accepted item and queues the mixed item it yields.
    function void take_pair(stereo_t x);
      int unsigned last;
      int unsigned rd_pos;
      stereo_t     old_pair;
      stereo_t     rd_pair;
      stereo_t     y;
      last = (echo_length > FRAMES - 1) ? FRAMES - 1 : echo_length;
      if (write_pos > last) write_pos = 0;

      old_pair = echo_slot[write_pos];
      echo_slot[write_pos].left  = mix_round(x.left, old_pair.left, feedback_depth,
                                             resd_pkg::ZERO99_Q16 + feedback_depth);
      echo_slot[write_pos].right = mix_round(x.right, old_pair.right, feedback_depth,
                                             resd_pkg::ZERO99_Q16 + feedback_depth);

      // The read walks backward; with no wet gain the item passes through.
      if (wet_level != 0) begin
        rd_pos  = last - write_pos;
        rd_pair = echo_slot[rd_pos];
        y.left  = mix_round(x.left, rd_pair.left, wet_level,
                            resd_pkg::ONE_Q16 + wet_level);
        y.right = mix_round(x.right, rd_pair.right, wet_level,
                            resd_pkg::ONE_Q16 + wet_level);
      end else begin
        y = x;
      end

      write_pos++;
      if (write_pos > last) write_pos = 0;
      expected_mix.push_back(y);
      accepted++;
    endfunction

    // Compares one output item with the oldest prediction.
    function void check_mix(stereo_t got);
      stereo_t want;
      if (expected_mix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output item with none expected: left %0d right %0d",
                   got.left, got.right);
        return;
      end
      want = expected_mix.pop_front();
      checked++;
      if (got.left !== want.left || got.right !== want.right) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output item %0d: left expected %0d got %0d, right expected %0d got %0d",
                   checked, want.left, got.left, want.right, got.right);
      end
    endfunction
  endclass

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_tvalid   = 1'b0;
  logic                          in_tready;
  logic [47:0]                   in_tdata    = '0;   // left_in [23:0], right_in [47:24]
  logic                          out_tvalid;
  logic                          out_tready  = 1'b0;
  logic [47:0]                   out_tdata;          // left_out [23:0], right_out [47:24]
  logic                          cfg_psel    = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite  = 1'b0;
  logic [resd_pkg::CFG_AW-1:0]   cfg_paddr   = '0;
  logic [resd_pkg::CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [resd_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                          cfg_pready;

  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int reg_writes    = 0;

  echo_mix_tracker mix_track = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reverse_echo_stereo_delay #(
    .MAX_FRAMES(FRAMES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_tready  <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Every output item handed over is checked.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mix_track.check_mix(out_tdata);
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("ERROR: timeout with %0d items still expected", mix_track.expected_mix.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic stereo_t make_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    stereo_t p;
    p.left  = l;
    p.right = r;
    return p;
  endfunction

  // Mostly full-range samples, with extremes and values near zero mixed in.
  function automatic logic signed [SW-1:0] random_sample();
    int          near_zero;
    int unsigned raw;
    raw       = $urandom();
    near_zero = int'($urandom_range(0, 511)) - 256;
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return near_zero[SW-1:0];
      default: return raw[SW-1:0];
    endcase
  endfunction

  // Offers one item after a random idle stretch and waits until it is taken.
  task automatic send_pair(input stereo_t pair, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pair;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mix_track.take_pair(pair);
  endtask

  // Stops offering items until every expected item has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (mix_track.expected_mix.size() != 0);
  endtask

  // One register write: setup phase, then access phase. Back-to-back writes keep psel high.
  task automatic cfg_write(input logic [1:0] idx, input logic [resd_pkg::CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mix_track.write_reg(idx, value);
    reg_writes++;
  endtask

  task automatic cfg_release();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Random setting for one phase; the depth write, which rewinds the position, is optional.
  task automatic program_random();
    logic [resd_pkg::CFG_DW-1:0] len_val;
    logic [resd_pkg::CFG_DW-1:0] depth_val;
    logic [resd_pkg::CFG_DW-1:0] wet_val;
    case ($urandom_range(0, 9))
      0: len_val = '0;
      1: len_val = $urandom();
      2: len_val = FRAMES - 1;
      default: len_val = $urandom_range(1, 48);
    endcase
    case ($urandom_range(0, 3))
      0: depth_val = '0;
      1: depth_val = 32'h0000_FFFF;
      default: depth_val = $urandom();
    endcase
    case ($urandom_range(0, 4))
      0: wet_val = '0;
      1: wet_val = 32'h0000_FFFF;
      default: wet_val = $urandom();
    endcase
    cfg_write(resd_pkg::REG_ECHO_LENGTH, len_val);
    if ($urandom_range(0, 1) == 1) cfg_write(resd_pkg::REG_FEEDBACK_DEPTH, depth_val);
    cfg_write(resd_pkg::REG_WET_LEVEL, wet_val);
    cfg_release();
  endtask

  initial begin
    int phase;
    int k;
    int mode;
    int idle_pct;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset: dry passthrough, store gain above one with zero depth.
    send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN), 0);
    send_pair(make_pair(SAMPLE_MIN, SAMPLE_MAX), 0);
    send_pair(make_pair('0, '0), 0);
    send_pair(make_pair(-24'sd1, 24'sd1), 0);

    // Full feedback and full wet on a short window with an even end, so the read meets the write slot.
    // The length value carries junk above its 17 bits.
    wait_drained();
    cfg_write(resd_pkg::REG_ECHO_LENGTH, 32'hFFFE_0006);
    cfg_write(resd_pkg::REG_FEEDBACK_DEPTH, 32'h0000_FFFF);
    cfg_write(resd_pkg::REG_WET_LEVEL, 32'h0000_FFFF);
    cfg_release();
    send_pair(make_pair(SAMPLE_MAX, SAMPLE_MAX), 0);
    send_pair(make_pair(SAMPLE_MIN, SAMPLE_MIN), 0);
    send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN), 0);
    send_pair(make_pair(24'sd12345, -24'sd54321), 0);
    for (k = 0; k < 4; k++) send_pair(make_pair(random_sample(), random_sample()), 0);

    // Length beyond the store, a write to a missing register, junk above gain bits.
    wait_drained();
    cfg_write(resd_pkg::REG_ECHO_LENGTH, 32'hFFFF_FFFF);
    cfg_write(resd_pkg::REG_FEEDBACK_DEPTH, 32'hFFFF_1234);
    cfg_write(REG_SPARE, $urandom());
    cfg_write(resd_pkg::REG_WET_LEVEL, 32'h5A5A_8000);
    cfg_release();
    for (k = 0; k < 4; k++) send_pair(make_pair(random_sample(), random_sample()), 0);

    // Shrinking the window below the current position restarts it at slot zero.
    wait_drained();
    cfg_write(resd_pkg::REG_ECHO_LENGTH, 32'd2);
    cfg_release();
    for (k = 0; k < 5; k++) send_pair(make_pair(random_sample(), random_sample()), 0);

    // Random phases, cycling through the idling patterns.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      program_random();
      mode      = phase % 4;
      idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 8 : 0;
      stall_pct = (mode == 2) ? 47 : (mode == 3) ? 8 : 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 2 && k == 10) hold_requests++;
        if (phase == 5 && k == 50) wait_drained();
        send_pair(make_pair(random_sample(), random_sample()), idle_pct);
      end
    end

    // Drain, then give any stray output item time to show up.
    wait_drained();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mix_track.expected_mix.size() != 0)
      $display("ERROR: %0d expected output items never arrived",
               mix_track.expected_mix.size());
    if (mix_track.mismatches > 10)
      $display("Note: %0d mismatches in total, only the first ten shown",
               mix_track.mismatches);
    $display("Covered %0d stereo items and %0d register writes over %0d random phases.",
             mix_track.accepted, reg_writes, PHASES);
    $display("Checked %0d output items, including a long output hold-off and a full drain.",
             mix_track.checked);
    if (mix_track.mismatches == 0 && mix_track.expected_mix.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> reverse_echo_stereo_delay.f
+incdir+src
src/resd_pkg.sv
src/resd_ram.sv
src/resd_mix_div.sv
src/reverse_echo_stereo_delay.sv
test/tb.sv
